FILE: rtl/srt_sched_pkg.sv
`timescale 1ns / 1ps

package srt_sched_pkg;

  localparam int OP_W        = 2;
  localparam int ID_W        = 8;
  localparam int EST_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int ALPHA_W     = 9;
  localparam int FRAC_W      = 8;
  localparam int PROD_W      = ALPHA_W + EST_W;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_ADMIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
  localparam logic [OP_W-1:0] OP_PREEMPT  = 2'd2;
  localparam logic [OP_W-1:0] OP_IO       = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic FIFO = 1'b0;
  localparam logic SRT  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_Q8    = 4'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  proc_id;
    logic [EST_W-1:0] estimate_in;
    logic [EST_W-1:0] burst_ms;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     chosen_id;
    logic [EST_W-1:0]    estimate_out;
    logic [COUNT_W-1:0]  ready_count;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  proc_id;
    logic [EST_W-1:0] estimate;
    logic [EST_W-1:0] burst;
  } entry_t;

endpackage

FILE: rtl/srt_fifo_ready_scheduler.sv
`timescale 1ns / 1ps

// Ready-table scheduler with FIFO or shortest-remaining-time dispatch. A command is taken
// when start is high and busy is low; it enters a two-entry command queue, so busy rises
// only when both entries wait. Each command yields one result, shown for exactly one cycle
// with done high; the receiver cannot stall it and must take it in that cycle. Admit,
// preempted return and FIFO IO return are answered from idle; a FIFO dispatch passes
// through a remove state. An SRT IO return first registers the multiply of the estimate
// blend. An SRT dispatch scans the table one entry per cycle for the smallest estimate,
// then removes it. Commands queued behind a long dispatch wait.

module srt_fifo_ready_scheduler #(
  parameter int READY_SLOTS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  srt_sched_pkg::cmd_t                     cmd,
  output logic                                    busy,
  output logic                                    done,
  output srt_sched_pkg::result_t                  result,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [srt_sched_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [srt_sched_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                               policy_mode;
  logic [srt_sched_pkg::ALPHA_W-1:0]  alpha_q8;
  logic                               push;
  logic                               pop;
  logic                               queue_full;
  logic                               queue_empty;
  srt_sched_pkg::entry_t              push_entry;
  srt_sched_pkg::entry_t              pop_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= srt_sched_pkg::FIFO;
      alpha_q8    <= srt_sched_pkg::ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == srt_sched_pkg::REG_POLICY_MODE) begin
        policy_mode <= cfg_data[0];
      end else if (cfg_index == srt_sched_pkg::REG_ALPHA_Q8) begin
        alpha_q8 <= cfg_data[srt_sched_pkg::ALPHA_W-1:0];
      end
    end
  end

  srt_sched_front u_front (
    .start       (start),
    .cmd         (cmd),
    .policy_mode (policy_mode),
    .queue_full  (queue_full),
    .busy        (busy),
    .push        (push),
    .entry       (push_entry)
  );

  srt_sched_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  srt_sched_back #(
    .READY_SLOTS (READY_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (pop_entry),
    .empty       (queue_empty),
    .pop         (pop),
    .policy_mode (policy_mode),
    .alpha_q8    (alpha_q8),
    .done        (done),
    .result      (result)
  );

endmodule

FILE: rtl/srt_sched_front.sv
`timescale 1ns / 1ps

module srt_sched_front (
  input  logic                  start,
  input  srt_sched_pkg::cmd_t   cmd,
  input  logic                  policy_mode,
  input  logic                  queue_full,
  output logic                  busy,
  output logic                  push,
  output srt_sched_pkg::entry_t entry
);

  assign busy = queue_full;
  assign push = start && !queue_full;

  // A preempted process in SRT mode comes back with its burst already spent.
  always_comb begin
    entry.op       = cmd.op;
    entry.proc_id  = cmd.proc_id;
    entry.burst    = cmd.burst_ms;
    entry.estimate = cmd.estimate_in;
    if (cmd.op == srt_sched_pkg::OP_PREEMPT && policy_mode == srt_sched_pkg::SRT) begin
      if (cmd.estimate_in > cmd.burst_ms) begin
        entry.estimate = cmd.estimate_in - cmd.burst_ms;
      end else begin
        entry.estimate = '0;
      end
    end
  end

endmodule

FILE: rtl/srt_sched_queue.sv
`timescale 1ns / 1ps

module srt_sched_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  srt_sched_pkg::entry_t push_entry,
  input  logic                  pop,
  output srt_sched_pkg::entry_t pop_entry,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (srt_sched_pkg::QUEUE_DEPTH > 1) ?
                         $clog2(srt_sched_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(srt_sched_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST  = PTR_W'(srt_sched_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(srt_sched_pkg::QUEUE_DEPTH);

  srt_sched_pkg::entry_t slots [srt_sched_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == DEPTH);
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: rtl/srt_sched_back.sv
`timescale 1ns / 1ps

module srt_sched_back #(
  parameter int READY_SLOTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  srt_sched_pkg::entry_t                entry,
  input  logic                                 empty,
  output logic                                 pop,
  input  logic                                 policy_mode,
  input  logic [srt_sched_pkg::ALPHA_W-1:0]    alpha_q8,
  output logic                                 done,
  output srt_sched_pkg::result_t               result
);

  localparam int IDX_W = $clog2(READY_SLOTS);
  localparam int OCC_W = $clog2(READY_SLOTS + 1);
  localparam logic [OCC_W-1:0] SLOTS = OCC_W'(READY_SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REMOVE, S_BLEND} state_t;

  state_t state;

  logic [srt_sched_pkg::ID_W-1:0]    ids  [READY_SLOTS];
  logic [srt_sched_pkg::EST_W-1:0]   ests [READY_SLOTS];
  logic [OCC_W-1:0]                  occ;
  logic [IDX_W-1:0]                  idx;
  logic [IDX_W-1:0]                  best_pos;
  logic [srt_sched_pkg::ID_W-1:0]    best_id;
  logic [srt_sched_pkg::EST_W-1:0]   best_est;
  logic [srt_sched_pkg::PROD_W-1:0]  prod_burst;
  logic [srt_sched_pkg::PROD_W-1:0]  prod_est;

  logic [srt_sched_pkg::ALPHA_W-1:0] alpha_sat;
  logic [srt_sched_pkg::ALPHA_W-1:0] weight_est;
  logic [srt_sched_pkg::PROD_W:0]    blend_sum;
  logic [srt_sched_pkg::EST_W-1:0]   blend_est;
  logic [OCC_W-1:0]                  occ_last;
  logic [OCC_W-1:0]                  occ_inc;
  logic [srt_sched_pkg::EST_W-1:0]   scan_est;

  assign pop        = (state == S_IDLE) && !empty;
  assign alpha_sat  = (alpha_q8 > srt_sched_pkg::ALPHA_ONE) ? srt_sched_pkg::ALPHA_ONE
                                                            : alpha_q8;
  assign weight_est = srt_sched_pkg::ALPHA_ONE - alpha_sat;
  assign blend_sum  = {1'b0, prod_burst} + {1'b0, prod_est};
  assign blend_est  = blend_sum[srt_sched_pkg::EST_W+srt_sched_pkg::FRAC_W-1:
                                srt_sched_pkg::FRAC_W];
  assign occ_last   = occ - 1'b1;
  assign occ_inc    = occ + 1'b1;
  assign scan_est   = ests[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (entry.op)
              srt_sched_pkg::OP_ADMIT, srt_sched_pkg::OP_PREEMPT: begin
                done                <= 1'b1;
                result.chosen_id    <= entry.proc_id;
                result.estimate_out <= entry.estimate;
                if (occ == SLOTS) begin
                  result.status      <= srt_sched_pkg::ST_FULL;
                  result.ready_count <= srt_sched_pkg::COUNT_W'(occ);
                end else begin
                  ids[occ[IDX_W-1:0]]  <= entry.proc_id;
                  ests[occ[IDX_W-1:0]] <= entry.estimate;
                  occ                  <= occ_inc;
                  result.status        <= srt_sched_pkg::ST_OK;
                  result.ready_count   <= srt_sched_pkg::COUNT_W'(occ_inc);
                end
              end
              srt_sched_pkg::OP_DISPATCH: begin
                best_pos <= '0;
                best_id  <= ids[0];
                best_est <= ests[0];
                if (occ == '0) begin
                  done                <= 1'b1;
                  result.status       <= srt_sched_pkg::ST_EMPTY;
                  result.chosen_id    <= '0;
                  result.estimate_out <= '0;
                  result.ready_count  <= '0;
                end else if (policy_mode == srt_sched_pkg::SRT && occ != OCC_W'(1)) begin
                  idx   <= IDX_W'(1);
                  state <= S_SCAN;
                end else begin
                  state <= S_REMOVE;
                end
              end
              default: begin
                if (policy_mode == srt_sched_pkg::SRT) begin
                  prod_burst <= srt_sched_pkg::PROD_W'(alpha_sat) *
                                srt_sched_pkg::PROD_W'(entry.burst);
                  prod_est   <= srt_sched_pkg::PROD_W'(weight_est) *
                                srt_sched_pkg::PROD_W'(entry.estimate);
                  best_id    <= entry.proc_id;
                  state      <= S_BLEND;
                end else begin
                  done                <= 1'b1;
                  result.status       <= srt_sched_pkg::ST_OK;
                  result.chosen_id    <= entry.proc_id;
                  result.estimate_out <= entry.estimate;
                  result.ready_count  <= srt_sched_pkg::COUNT_W'(occ);
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // Strict compare keeps the earliest entry on a tie.
          if (scan_est < best_est) begin
            best_pos <= idx;
            best_id  <= ids[idx];
            best_est <= scan_est;
          end
          if (OCC_W'(idx) == occ_last) begin
            state <= S_REMOVE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_REMOVE: begin
          for (int i = 0; i < READY_SLOTS - 1; i++) begin
            if (IDX_W'(i) >= best_pos) begin
              ids[i]  <= ids[i+1];
              ests[i] <= ests[i+1];
            end
          end
          occ                 <= occ_last;
          done                <= 1'b1;
          result.status       <= srt_sched_pkg::ST_OK;
          result.chosen_id    <= best_id;
          result.estimate_out <= best_est;
          result.ready_count  <= srt_sched_pkg::COUNT_W'(occ_last);
          state               <= S_IDLE;
        end
        S_BLEND: begin
          done                <= 1'b1;
          result.status       <= srt_sched_pkg::ST_OK;
          result.chosen_id    <= best_id;
          result.estimate_out <= blend_est;
          result.ready_count  <= srt_sched_pkg::COUNT_W'(occ);
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/srt_sched_checker.sv
`timescale 1ns / 1ps

module srt_sched_checker #(
  parameter int READY_SLOTS = 16
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  busy,
  input logic                                  done,
  input srt_sched_pkg::result_t                result
);

  // After reset no result is pending and the command queue is open.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("result or busy seen right after reset");

  // A dispatch on an empty table reports nothing chosen and an empty table.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && result.status == srt_sched_pkg::ST_EMPTY |->
      result.chosen_id == '0 && result.estimate_out == '0 && result.ready_count == '0)
    else $error("empty dispatch carries nonzero fields");

  // A full table reports every slot occupied.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status == srt_sched_pkg::ST_FULL |->
      result.ready_count == srt_sched_pkg::COUNT_W'(READY_SLOTS))
    else $error("full status with a count below the table size");

endmodule

bind srt_fifo_ready_scheduler srt_sched_checker #(
  .READY_SLOTS (READY_SLOTS)
) u_checker (.*);

FILE: test/tb_srt_fifo_ready_scheduler.sv
`timescale 1ns / 1ps

module tb_srt_fifo_ready_scheduler;
  import srt_sched_pkg::*;

  localparam int READY_SLOTS  = 16;
  localparam int SEGMENTS     = 6;
  localparam int ITEMS_PER_SEG = 305;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 24;

  class ready_table_scoreboard;
    logic [ID_W-1:0]    slot_id [READY_SLOTS];
    logic [EST_W-1:0]   slot_est [READY_SLOTS];
    int unsigned        occupancy;
    logic               policy;
    logic [ALPHA_W-1:0] alpha;
    result_t            pending_outcomes[$];
    int unsigned        errors;

    function new();
      occupancy = 0;
      policy = FIFO;
      alpha = ALPHA_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_POLICY_MODE: policy = data[0];
        REG_ALPHA_Q8:    alpha = data[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    function bit enqueue(logic [ID_W-1:0] id, logic [EST_W-1:0] est);
      if (occupancy >= READY_SLOTS) begin
        return 1'b0;
      end
      slot_id[occupancy] = id;
      slot_est[occupancy] = est;
      occupancy++;
      return 1'b1;
    endfunction

    // Works out the result of one accepted command and updates the table.
    function void predict_outcome(cmd_t c);
      result_t            r;
      int unsigned        pos;
      logic [ALPHA_W-1:0] a_sat;
      logic [PROD_W:0]    blend;
      r.status = ST_OK;
      r.chosen_id = c.proc_id;
      r.estimate_out = c.estimate_in;
      case (c.op)
        OP_ADMIT: begin
          if (!enqueue(c.proc_id, c.estimate_in)) r.status = ST_FULL;
        end
        OP_DISPATCH: begin
          if (occupancy == 0) begin
            r.status = ST_EMPTY;
            r.chosen_id = '0;
            r.estimate_out = '0;
          end else begin
            pos = 0;
            if (policy == SRT) begin
              for (int i = 1; i < occupancy; i++) begin
                if (slot_est[i] < slot_est[pos]) pos = i;
              end
            end
            r.chosen_id = slot_id[pos];
            r.estimate_out = slot_est[pos];
            for (int i = pos; i + 1 < occupancy; i++) begin
              slot_id[i] = slot_id[i+1];
              slot_est[i] = slot_est[i+1];
            end
            occupancy--;
          end
        end
        OP_PREEMPT: begin
          if (policy == SRT) begin
            r.estimate_out = (c.estimate_in > c.burst_ms) ? c.estimate_in - c.burst_ms : '0;
          end
          if (!enqueue(c.proc_id, r.estimate_out)) r.status = ST_FULL;
        end
        default: begin
          if (policy == SRT) begin
            a_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
            blend = (PROD_W+1)'(a_sat) * (PROD_W+1)'(c.burst_ms)
                  + (PROD_W+1)'(ALPHA_ONE - a_sat) * (PROD_W+1)'(c.estimate_in);
            r.estimate_out = blend[FRAC_W +: EST_W];
          end
        end
      endcase
      r.ready_count = COUNT_W'(occupancy);
      pending_outcomes.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with no transaction pending, got %h", $time, got);
        errors++;
        return;
      end
      exp = pending_outcomes.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d, got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.chosen_id !== exp.chosen_id) begin
        $display("%0t: chosen_id expected %0h, got %0h", $time, exp.chosen_id, got.chosen_id);
        errors++;
      end
      if (got.estimate_out !== exp.estimate_out) begin
        $display("%0t: estimate_out expected %0h, got %0h", $time, exp.estimate_out,
                 got.estimate_out);
        errors++;
      end
      if (got.ready_count !== exp.ready_count) begin
        $display("%0t: ready_count expected %0d, got %0d", $time, exp.ready_count,
                 got.ready_count);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  cmd_t                   cmd = '0;
  logic                   busy;
  logic                   done;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ready_table_scoreboard sb;

  srt_fifo_ready_scheduler #(
    .READY_SLOTS(READY_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  task automatic issue(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [EST_W-1:0] est,
                       logic [EST_W-1:0] burst, int unsigned gap);
    cmd_t c;
    c.op = op;
    c.proc_id = id;
    c.estimate_in = est;
    c.burst_ms = burst;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.predict_outcome(c);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic settle();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    while (sb.pending_outcomes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [EST_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return EST_W'($urandom_range(0, 1000));
      default: return EST_W'($urandom);
    endcase
  endfunction

  initial begin
    logic               seg_policy [SEGMENTS];
    logic [ALPHA_W-1:0] seg_alpha [SEGMENTS];
    logic [OP_W-1:0]    op;
    int unsigned        idle_pct;
    int unsigned        admit_pct;
    int unsigned        roll;
    int unsigned        gap;
    seg_policy = '{FIFO, SRT, SRT, FIFO, SRT, SRT};
    seg_alpha = '{9'd0, 9'd256, 9'd511, 9'd256, 9'd0, 9'd128};
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_POLICY_MODE, CFG_DATA_W'(SRT));
    write_reg(REG_ALPHA_Q8, 32'd511);
    cfg_valid <= 1'b0;
    @(posedge clk);

    issue(OP_DISPATCH, 8'hFF, '1, '1, 0);
    issue(OP_IO, 8'h00, 32'hFFFF_FFFF, 32'h0, 0);
    issue(OP_IO, 8'hFF, 32'h0, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < READY_SLOTS; i++) begin
      issue(OP_ADMIT, (i == READY_SLOTS - 1) ? 8'hFF : ID_W'(i * 17),
            (i == 0) ? 32'hFFFF_FFFF : (i == 4 || i == 11) ? 32'd7 : EST_W'(100 + i),
            32'h0, 0);
    end
    issue(OP_ADMIT, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA, 0);
    issue(OP_PREEMPT, 8'h55, 32'd5, 32'd9, 0);
    issue(OP_DISPATCH, 8'h00, '0, '0, 0);
    issue(OP_PREEMPT, 8'h33, 32'd9, 32'd5, 0);
    issue(OP_DISPATCH, 8'h00, '0, '0, 0);
    issue(OP_DISPATCH, 8'h00, '0, '0, 0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      if (seg == SEGMENTS - 1) seg_alpha[seg] = ALPHA_W'($urandom_range(1, 255));
      write_reg(REG_POLICY_MODE, CFG_DATA_W'(seg_policy[seg]));
      write_reg(REG_ALPHA_Q8, CFG_DATA_W'(seg_alpha[seg]));
      cfg_valid <= 1'b0;
      idle_pct = (seg < 2) ? 20 : (seg < 4) ? 63 : 0;
      admit_pct = 40;
      for (int n = 0; n < ITEMS_PER_SEG; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: admit_pct = 20;
            1: admit_pct = 45;
            default: admit_pct = 70;
          endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < admit_pct) begin
          op = OP_ADMIT;
        end else begin
          case ($urandom_range(0, 3))
            0, 1: op = OP_DISPATCH;
            2: op = OP_PREEMPT;
            default: op = OP_IO;
          endcase
        end
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        issue(op, ID_W'($urandom_range(0, 255)), pick_value(), pick_value(), gap);
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
